### sv/psehit_pkg.sv
package psehit_pkg;

   localparam int MAX_VERTICES_DEF = 16;

   localparam int COORD_W = 32;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int ACC_W   = PROD_W + 2;
   localparam int MSQ_W   = PROD_W + 1;
   localparam int NUM_W   = ACC_W + DIFF_W;
   localparam int ITER_W  = 6;
   localparam int STEP_W  = 4;
   localparam int NUM_PRODUCTS = 8;

   localparam logic [COORD_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [COORD_W-1:0] SAT_MIN = 32'h8000_0000;

   typedef enum logic [1:0] {
      CMD_OWN   = 2'd0,
      CMD_OTHER = 2'd1,
      CMD_TEST  = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_P,
      ST_LD_P,
      ST_LD_K,
      ST_MUL,
      ST_CHECK,
      ST_NUM,
      ST_OVF,
      ST_DIV,
      ST_CLIP,
      ST_OUT
   } state_type;

   // True when the fraction a/den lies in [0,1).
   function automatic logic frac_ok(input logic signed [ACC_W-1:0] a,
                                    input logic signed [ACC_W-1:0] den);
      logic ok;
      if (den == '0) begin
         ok = 1'b0;
      end else if (!den[ACC_W-1]) begin
         ok = !a[ACC_W-1] && (a < den);
      end else begin
         ok = (a[ACC_W-1] || (a == '0)) && (den < a);
      end
      return ok;
   endfunction

endpackage

### sv/psehit_ram.sv
module psehit_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/polygon_spoke_edge_hit_test.sv
// Spoke/edge hit test between two polygons held in two vertex tables. Requests
// carry a command in req_tuser: append an own vertex, append an other vertex,
// clear both tables, or run a test at the center point in req_tdata. Appends
// and clears give no response; appends beyond MAX_VERTICES
// are dropped. A test gives exactly one response. It walks every own vertex
// against every edge of the other polygon through one shared 33x33 multiplier:
// each pair passes through the table read states RD_P, LD_P and LD_K, eight
// products with their accumulate, and one compare. On the first hit the two
// clip components come from a bit-serial multiply and a restoring divide each.
// The block takes no new request while a test runs; the response register
// holds a result until it is taken.
module polygon_spoke_edge_hit_test #(
   parameter int MAX_VERTICES = psehit_pkg::MAX_VERTICES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,   // coord_x, coord_y
   input  logic [1:0]   req_tuser,   // cmd
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // clip_x, clip_y, contact_x, contact_y
   output logic         rsp_tuser    // hit
);

   localparam int IDX_W = $clog2(MAX_VERTICES);
   localparam int CNT_W = IDX_W + 1;
   localparam int CW = psehit_pkg::COORD_W;
   localparam int DW = psehit_pkg::DIFF_W;
   localparam int PW = psehit_pkg::PROD_W;
   localparam int AW = psehit_pkg::ACC_W;
   localparam int MW = psehit_pkg::MSQ_W;
   localparam int NW = psehit_pkg::NUM_W;
   localparam int TW = psehit_pkg::ITER_W;
   localparam int SW = psehit_pkg::STEP_W;
   localparam logic [CW-1:0] SAT_MAX_C = psehit_pkg::SAT_MAX;
   localparam logic [CW-1:0] SAT_MIN_C = psehit_pkg::SAT_MIN;

   psehit_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0] own_cnt_ff, own_cnt_in, oth_cnt_ff, oth_cnt_in;
   logic [IDX_W-1:0] i_ff, i_in, j_ff, j_in;
   logic signed [CW-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [CW-1:0] ox_ff, ox_in, oy_ff, oy_in, px_ff, px_in, py_ff, py_in;
   logic signed [DW-1:0] d0x_ff, d0x_in, d0y_ff, d0y_in;
   logic signed [DW-1:0] ex_ff, ex_in, ey_ff, ey_in, d1x_ff, d1x_in, d1y_ff, d1y_in;
   logic [SW-1:0] step_ff, step_in;
   logic signed [PW-1:0] prod_ff, prod_in, hold_ff, hold_in;
   logic signed [AW-1:0] a0_ff, a0_in, cr_ff, cr_in, a1_ff, a1_in;
   logic [MW-1:0] msq_ff, msq_in, rem_ff, rem_in;
   logic [AW-1:0] magb_ff, magb_in;
   logic sb_ff, sb_in, comp_ff, comp_in, neg_ff, neg_in, ovf_ff, ovf_in, hit_ff, hit_in;
   logic [DW-1:0] magf_ff, magf_in;
   logic [NW-1:0] num_ff, num_in;
   logic [TW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] quo_ff, quo_in, clipx_ff, clipx_in, clipy_ff, clipy_in;
   logic rsp_tvalid_ff, rsp_tvalid_in, rsp_tuser_ff, rsp_tuser_in;
   logic [127:0] rsp_tdata_ff, rsp_tdata_in;

   logic req_accept;
   logic signed [CW-1:0] req_x, req_y, own_x, own_y, oth_x, oth_y;
   logic own_we, oth_we;
   logic [IDX_W-1:0] own_rd_addr, oth_rd_addr, k_idx;
   logic [2*CW-1:0] own_rd, oth_rd;
   logic [CNT_W-1:0] j_next, i_next;
   logic signed [DW-1:0] ma, mb;
   logic [SW-1:0] sub_idx;
   logic signed [AW-1:0] pair_diff, b1;
   logic [MW:0] trial;
   logic qbit;
   logic [CW-1:0] clip_val;

   assign req_tready = (state_ff == psehit_pkg::ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign req_x = req_tdata[CW-1:0];
   assign req_y = req_tdata[2*CW-1:CW];
   assign own_x = own_rd[CW-1:0];
   assign own_y = own_rd[2*CW-1:CW];
   assign oth_x = oth_rd[CW-1:0];
   assign oth_y = oth_rd[2*CW-1:CW];

   assign j_next = CNT_W'(j_ff) + CNT_W'(1);
   assign i_next = CNT_W'(i_ff) + CNT_W'(1);
   assign k_idx  = (j_next < oth_cnt_ff) ? j_next[IDX_W-1:0] : '0;

   psehit_ram #(.WIDTH(2 * CW), .DEPTH(MAX_VERTICES)) u_own_ram (
      .clock   (clock),
      .wr_en   (own_we),
      .wr_addr (own_cnt_ff[IDX_W-1:0]),
      .wr_data (req_tdata),
      .rd_addr (own_rd_addr),
      .rd_data (own_rd)
   );

   psehit_ram #(.WIDTH(2 * CW), .DEPTH(MAX_VERTICES)) u_oth_ram (
      .clock   (clock),
      .wr_en   (oth_we),
      .wr_addr (oth_cnt_ff[IDX_W-1:0]),
      .wr_data (req_tdata),
      .rd_addr (oth_rd_addr),
      .rd_data (oth_rd)
   );

   // Shared multiplier operand select; step 8 only drains the last product.
   always_comb begin
      case (step_ff)
         SW'(0):  begin ma = ex_ff;  mb = d0y_ff; end
         SW'(1):  begin ma = ey_ff;  mb = d0x_ff; end
         SW'(2):  begin ma = d1x_ff; mb = d0y_ff; end
         SW'(3):  begin ma = d1y_ff; mb = d0x_ff; end
         SW'(4):  begin ma = ey_ff;  mb = d1x_ff; end
         SW'(5):  begin ma = ex_ff;  mb = d1y_ff; end
         SW'(6):  begin ma = d1x_ff; mb = d1x_ff; end
         SW'(7):  begin ma = d1y_ff; mb = d1y_ff; end
         default: begin ma = '0;     mb = '0;     end
      endcase
   end

   assign prod_in   = ma * mb;
   assign sub_idx   = step_ff - SW'(1);
   assign pair_diff = AW'(hold_ff) - AW'(prod_ff);
   assign b1        = a1_ff - cr_ff;
   assign trial     = {rem_ff, num_ff[CW-1]};
   assign qbit      = (trial >= {1'b0, msq_ff});

   always_comb begin
      if (neg_ff) begin
         clip_val = (ovf_ff || quo_ff > SAT_MIN_C) ? SAT_MIN_C : (~quo_ff + CW'(1));
      end else begin
         clip_val = (ovf_ff || quo_ff > SAT_MAX_C) ? SAT_MAX_C : quo_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      own_cnt_in = own_cnt_ff;  oth_cnt_in = oth_cnt_ff;
      i_in = i_ff;  j_in = j_ff;
      cx_in = cx_ff;  cy_in = cy_ff;
      ox_in = ox_ff;  oy_in = oy_ff;  px_in = px_ff;  py_in = py_ff;
      d0x_in = d0x_ff;  d0y_in = d0y_ff;  ex_in = ex_ff;  ey_in = ey_ff;
      d1x_in = d1x_ff;  d1y_in = d1y_ff;
      step_in = step_ff;  hold_in = hold_ff;
      a0_in = a0_ff;  cr_in = cr_ff;  a1_in = a1_ff;  msq_in = msq_ff;
      magb_in = magb_ff;  sb_in = sb_ff;  comp_in = comp_ff;  neg_in = neg_ff;
      ovf_in = ovf_ff;  hit_in = hit_ff;  magf_in = magf_ff;  num_in = num_ff;
      cnt_in = cnt_ff;  rem_in = rem_ff;  quo_in = quo_ff;
      clipx_in = clipx_ff;  clipy_in = clipy_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tuser_in = rsp_tuser_ff;  rsp_tdata_in = rsp_tdata_ff;
      own_we = 1'b0;  oth_we = 1'b0;
      own_rd_addr = i_ff;
      oth_rd_addr = j_ff;

      case (state_ff)
         psehit_pkg::ST_IDLE: begin
            if (req_accept) begin
               case (psehit_pkg::cmd_type'(req_tuser))
                  psehit_pkg::CMD_OWN: begin
                     if (own_cnt_ff < CNT_W'(MAX_VERTICES)) begin
                        own_we = 1'b1;
                        own_cnt_in = own_cnt_ff + CNT_W'(1);
                     end
                  end
                  psehit_pkg::CMD_OTHER: begin
                     if (oth_cnt_ff < CNT_W'(MAX_VERTICES)) begin
                        oth_we = 1'b1;
                        oth_cnt_in = oth_cnt_ff + CNT_W'(1);
                     end
                  end
                  psehit_pkg::CMD_CLEAR: begin
                     own_cnt_in = '0;
                     oth_cnt_in = '0;
                  end
                  default: begin
                     cx_in = req_x;
                     cy_in = req_y;
                     i_in = '0;
                     j_in = '0;
                     hit_in = 1'b0;
                     if (own_cnt_ff == '0 || oth_cnt_ff == '0) begin
                        state_in = psehit_pkg::ST_OUT;
                     end else begin
                        state_in = psehit_pkg::ST_RD_P;
                     end
                  end
               endcase
            end
         end
         psehit_pkg::ST_RD_P: begin
            state_in = psehit_pkg::ST_LD_P;
         end
         psehit_pkg::ST_LD_P: begin
            oth_rd_addr = k_idx;
            ox_in = own_x;
            oy_in = own_y;
            d0x_in = DW'(own_x) - DW'(cx_ff);
            d0y_in = DW'(own_y) - DW'(cy_ff);
            px_in = oth_x;
            py_in = oth_y;
            ex_in = DW'(oth_x) - DW'(cx_ff);
            ey_in = DW'(oth_y) - DW'(cy_ff);
            state_in = psehit_pkg::ST_LD_K;
         end
         psehit_pkg::ST_LD_K: begin
            d1x_in = DW'(oth_x) - DW'(px_ff);
            d1y_in = DW'(oth_y) - DW'(py_ff);
            step_in = '0;
            state_in = psehit_pkg::ST_MUL;
         end
         psehit_pkg::ST_MUL: begin
            // Products come in pairs: the first is held, the second closes it.
            if (step_ff != '0) begin
               if (!sub_idx[0]) begin
                  hold_in = prod_ff;
               end else begin
                  case (sub_idx[SW-1:1])
                     (SW-1)'(0): a0_in = pair_diff;
                     (SW-1)'(1): cr_in = pair_diff;
                     (SW-1)'(2): a1_in = pair_diff;
                     default:    msq_in = MW'(hold_ff) + MW'(prod_ff);
                  endcase
               end
            end
            step_in = step_ff + SW'(1);
            if (step_ff == SW'(psehit_pkg::NUM_PRODUCTS)) begin
               state_in = psehit_pkg::ST_CHECK;
            end
         end
         psehit_pkg::ST_CHECK: begin
            if (psehit_pkg::frac_ok(a0_ff, -cr_ff) && psehit_pkg::frac_ok(a1_ff, cr_ff)) begin
               hit_in = 1'b1;
               sb_in = b1[AW-1];
               magb_in = b1[AW-1] ? AW'(-b1) : AW'(b1);
               magf_in = d1y_ff[DW-1] ? DW'(-d1y_ff) : DW'(d1y_ff);
               neg_in = b1[AW-1] ^ d1y_ff[DW-1];
               comp_in = 1'b0;
               num_in = '0;
               cnt_in = '0;
               state_in = psehit_pkg::ST_NUM;
            end else if (j_next < oth_cnt_ff) begin
               j_in = j_next[IDX_W-1:0];
               state_in = psehit_pkg::ST_RD_P;
            end else begin
               j_in = '0;
               if (i_next < own_cnt_ff) begin
                  i_in = i_next[IDX_W-1:0];
                  state_in = psehit_pkg::ST_RD_P;
               end else begin
                  state_in = psehit_pkg::ST_OUT;
               end
            end
         end
         psehit_pkg::ST_NUM: begin
            // Shift-add multiply, most significant multiplier bit first.
            num_in = {num_ff[NW-2:0], 1'b0} + (magf_ff[DW-1] ? NW'(magb_ff) : '0);
            magf_in = {magf_ff[DW-2:0], 1'b0};
            cnt_in = cnt_ff + TW'(1);
            if (cnt_ff == TW'(DW - 1)) begin
               state_in = psehit_pkg::ST_OVF;
            end
         end
         psehit_pkg::ST_OVF: begin
            // A quotient of 2^32 or more saturates whatever its sign.
            ovf_in = (num_ff >= NW'({msq_ff, {CW{1'b0}}}));
            rem_in = num_ff[CW +: MW];
            cnt_in = '0;
            state_in = psehit_pkg::ST_DIV;
         end
         psehit_pkg::ST_DIV: begin
            rem_in = qbit ? MW'(trial - {1'b0, msq_ff}) : trial[MW-1:0];
            quo_in = {quo_ff[CW-2:0], qbit};
            num_in = {num_ff[NW-2:0], 1'b0};
            cnt_in = cnt_ff + TW'(1);
            if (cnt_ff == TW'(CW - 1)) begin
               state_in = psehit_pkg::ST_CLIP;
            end
         end
         psehit_pkg::ST_CLIP: begin
            if (!comp_ff) begin
               clipx_in = clip_val;
               comp_in = 1'b1;
               magf_in = d1x_ff[DW-1] ? DW'(-d1x_ff) : DW'(d1x_ff);
               neg_in = !(sb_ff ^ d1x_ff[DW-1]);
               num_in = '0;
               cnt_in = '0;
               state_in = psehit_pkg::ST_NUM;
            end else begin
               clipy_in = clip_val;
               state_in = psehit_pkg::ST_OUT;
            end
         end
         psehit_pkg::ST_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tuser_in = hit_ff;
               rsp_tdata_in = hit_ff ? {oy_ff, ox_ff, clipy_ff, clipx_ff} : '0;
               state_in = psehit_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = psehit_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= psehit_pkg::ST_IDLE;
         own_cnt_ff <= '0;
         oth_cnt_ff <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         own_cnt_ff <= own_cnt_in;
         oth_cnt_ff <= oth_cnt_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in;  j_ff <= j_in;
      cx_ff <= cx_in;  cy_ff <= cy_in;
      ox_ff <= ox_in;  oy_ff <= oy_in;  px_ff <= px_in;  py_ff <= py_in;
      d0x_ff <= d0x_in;  d0y_ff <= d0y_in;  ex_ff <= ex_in;  ey_ff <= ey_in;
      d1x_ff <= d1x_in;  d1y_ff <= d1y_in;
      step_ff <= step_in;  prod_ff <= prod_in;  hold_ff <= hold_in;
      a0_ff <= a0_in;  cr_ff <= cr_in;  a1_ff <= a1_in;  msq_ff <= msq_in;
      magb_ff <= magb_in;  sb_ff <= sb_in;  comp_ff <= comp_in;  neg_ff <= neg_in;
      ovf_ff <= ovf_in;  hit_ff <= hit_in;  magf_ff <= magf_in;  num_ff <= num_in;
      cnt_ff <= cnt_in;  rem_ff <= rem_in;  quo_ff <= quo_in;
      clipx_ff <= clipx_in;  clipy_ff <= clipy_in;
      rsp_tuser_ff <= rsp_tuser_in;  rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tdata  = rsp_tdata_ff;

`ifndef SYNTHESIS
   a_own_cnt_max: assert property (@(posedge clock) disable iff (reset)
      own_cnt_ff <= CNT_W'(MAX_VERTICES) && oth_cnt_ff <= CNT_W'(MAX_VERTICES))
      else $error("vertex count beyond table depth");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff) == psehit_pkg::ST_OUT)
      else $error("response raised outside the output state");

   a_nohit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && !rsp_tuser_ff |-> rsp_tdata_ff == '0)
      else $error("response without hit carries nonzero data");

   a_test_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tuser == psehit_pkg::CMD_TEST |=> state_ff != psehit_pkg::ST_IDLE)
      else $error("test request did not start");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == psehit_pkg::ST_DIV |-> msq_ff != '0)
      else $error("division by zero edge length");
`endif

endmodule
